// ===== hdl/nscs_pkg.sv =====
package nscs_pkg;

	// Lookahead window and job sizes
	localparam int WIN_DEPTH = 4;
	localparam int JOB_BYTES = WIN_DEPTH + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [31:0] START_CODE = 32'h0000_0001;
	localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
	localparam logic [15:0] LENGTH_LIMIT_RESET = 16'hffff;

	// Register index decoded from the word address
	localparam logic REG_LENGTH_LIMIT = 1'b0;

	// One job: the known bytes at an accept and the start code hits among them
	typedef struct packed {
		logic [JOB_BYTES-1:0][7:0] bytes;
		logic [JOB_BYTES-1:0] sc;
		logic [2:0] cnt;
		logic flush;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} job_push_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_head_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== hdl/nscs_if.sv =====
interface nscs_in_if;
	logic valid;
	logic ready;
	logic [7:0] byte_in;
	logic buffer_end;

	modport source (output valid, output byte_in, output buffer_end, input ready);
	modport sink (input valid, input byte_in, input buffer_end, output ready);
endinterface

interface nscs_out_if;
	logic valid;
	logic ready;
	logic [7:0] byte_out;
	logic seg_first;
	logic seg_last;
	logic [4:0] nal_kind;

	modport source (output valid, output byte_out, output seg_first, output seg_last,
		output nal_kind, input ready);
	modport sink (input valid, input byte_out, input seg_first, input seg_last,
		input nal_kind, output ready);
endinterface

// ===== hdl/nal_start_code_splitter.sv =====
// A byte's result passes the job queue and the output register after the transfer that
// releases it from the four-byte lookahead window (four later bytes, or a buffer end).
// Throughput: one input transfer per cycle unless the queue is full; a buffer-end
// transfer emits up to five results, one per cycle while out_ch is ready, and a
// four-job queue absorbs the burst. Reset (arst_n low, asynchronous): window, queue,
// segment state and output cleared; length_limit returns to 65535.
module nal_start_code_splitter #(
	parameter int LENGTH_BITS = 17
) (
	input  logic clk,
	input  logic arst_n,
	nscs_in_if.sink in_ch,
	nscs_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	nscs_pkg::job_push_t job_push;
	nscs_pkg::job_head_t head;
	nscs_pkg::queue_stat_t q_stat;
	logic pop;
	logic [2:0] k_idx;
	logic [15:0] length_limit_q;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == nscs_pkg::REG_LENGTH_LIMIT) ? {16'h0000, length_limit_q}
		: 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			length_limit_q <= nscs_pkg::LENGTH_LIMIT_RESET;
		else if (psel && penable && pwrite && pready &&
			(paddr[2] == nscs_pkg::REG_LENGTH_LIMIT))
			length_limit_q <= pwdata[15:0];
	end

	nscs_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_ch (in_ch),
		.q_stat (q_stat),
		.job_push (job_push)
	);

	nscs_queue u_queue (
		.clk (clk),
		.arst_n (arst_n),
		.job_push (job_push),
		.pop (pop),
		.q_stat (q_stat),
		.head (head)
	);

	nscs_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head (head),
		.length_limit (length_limit_q),
		.pop (pop),
		.k_idx (k_idx),
		.out_ch (out_ch)
	);

	// A job is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push.push |-> !q_stat.full)
		else $error("job pushed into full queue");

	// The byte index stays within the head job
	a_index_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		head.valid |-> (k_idx < head.job.cnt))
		else $error("byte index beyond head job");

	// NAL type is shown only on the last byte of a segment
	a_kind_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.seg_last) |-> (out_ch.nal_kind == 5'd0))
		else $error("nal_kind set on non-final byte");

	// After a segment's last byte is taken, the next result opens a segment
	a_first_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.seg_last && head.valid) |=>
		(out_ch.valid && out_ch.seg_first))
		else $error("segment did not open after last byte");

endmodule

// ===== hdl/nscs_front.sv =====
module nscs_front (
	input  logic clk,
	input  logic arst_n,
	nscs_in_if.sink in_ch,
	input  nscs_pkg::queue_stat_t q_stat,
	output nscs_pkg::job_push_t job_push
);

	logic [nscs_pkg::WIN_DEPTH-1:0][7:0] win_q;
	logic [2:0] held_q;

	logic accept;
	logic [nscs_pkg::JOB_BYTES-1:0][7:0] seq;
	logic [nscs_pkg::JOB_BYTES-1:0] sc;
	logic [2:0] n;
	logic win_full;

	assign in_ch.ready = !q_stat.full;
	assign accept = in_ch.valid && in_ch.ready;
	assign win_full = (held_q == 3'(nscs_pkg::WIN_DEPTH));
	assign n = held_q + 3'd1;

	// Line up the held bytes with the new one
	always_comb begin
		for (int j = 0; j < nscs_pkg::WIN_DEPTH; j++) begin
			if (3'(j) < held_q)
				seq[j] = win_q[j];
			else if (3'(j) == held_q)
				seq[j] = in_ch.byte_in;
			else
				seq[j] = 8'h00;
		end
		seq[nscs_pkg::WIN_DEPTH] = win_full ? in_ch.byte_in : 8'h00;
	end

	// Mark every position that opens a complete start code
	always_comb begin
		sc = '0;
		for (int j = 0; j < 2; j++)
			sc[j] = (3'(j + 3) < n) &&
				({seq[j], seq[j+1], seq[j+2], seq[j+3]} == nscs_pkg::START_CODE);
	end

	// Hand a job on at each flush or once the window is full
	always_comb begin
		job_push.push = accept && (in_ch.buffer_end || win_full);
		job_push.job.bytes = seq;
		job_push.job.sc = sc;
		job_push.job.flush = in_ch.buffer_end;
		job_push.job.cnt = in_ch.buffer_end ? n : 3'd1;
	end

	// Advance the lookahead window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			win_q <= '0;
		end else if (accept) begin
			if (in_ch.buffer_end) begin
				held_q <= '0;
			end else if (win_full) begin
				for (int j = 0; j < nscs_pkg::WIN_DEPTH; j++)
					win_q[j] <= seq[j+1];
			end else begin
				win_q[held_q[1:0]] <= in_ch.byte_in;
				held_q <= held_q + 3'd1;
			end
		end
	end

endmodule

// ===== hdl/nscs_queue.sv =====
module nscs_queue (
	input  logic clk,
	input  logic arst_n,
	input  nscs_pkg::job_push_t job_push,
	input  logic pop,
	output nscs_pkg::queue_stat_t q_stat,
	output nscs_pkg::job_head_t head
);

	nscs_pkg::job_t mem_q [nscs_pkg::QUEUE_DEPTH];
	logic [nscs_pkg::QPTR_W-1:0] wr_q;
	logic [nscs_pkg::QPTR_W-1:0] rd_q;
	logic [nscs_pkg::QCNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign q_stat.full = (cnt_q == nscs_pkg::QCNT_W'(nscs_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push = job_push.push && !q_stat.full;
	assign do_pop = pop && !q_stat.empty;

	assign head.valid = !q_stat.empty;
	assign head.job = mem_q[rd_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= job_push.job;
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/nscs_back.sv =====
module nscs_back #(
	parameter int LENGTH_BITS = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  nscs_pkg::job_head_t head,
	input  logic [15:0] length_limit,
	output logic pop,
	output logic [2:0] k_idx,
	nscs_out_if.source out_ch
);

	localparam int CMP_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

	logic [LENGTH_BITS-1:0] seg_len_q;
	logic [4:0] type_q;
	logic type_due_q;
	logic at_start_q;
	logic [2:0] k_q;

	logic out_valid_q;
	logic [7:0] byte_q;
	logic first_q;
	logic last_q;
	logic [4:0] kind_q;

	logic advance;
	logic at_end;
	logic first;
	logic [7:0] cur_byte;
	logic sc_next;
	logic [LENGTH_BITS-1:0] len0;
	logic [LENGTH_BITS-1:0] len1;
	logic [4:0] ts0;
	logic [4:0] ts1;
	logic td0;
	logic td1;
	logic last;

	assign k_idx = k_q;
	assign advance = head.valid && (!out_valid_q || out_ch.ready);
	assign at_end = (k_q == head.job.cnt - 3'd1);
	assign pop = advance && at_end;

	// Work out the marks and segment state for the current byte
	always_comb begin
		first = at_start_q;
		cur_byte = head.job.bytes[k_q];
		sc_next = (k_q < 3'd4) ? head.job.sc[k_q + 3'd1] : 1'b0;
		len0 = first ? '0 : seg_len_q;
		ts0 = first ? 5'd0 : type_q;
		td0 = first ? head.job.sc[k_q] : type_due_q;
		if (td0 && (len0 == LENGTH_BITS'(4))) begin
			ts1 = cur_byte[4:0] & nscs_pkg::NAL_TYPE_MASK;
			td1 = 1'b0;
		end else begin
			ts1 = ts0;
			td1 = td0;
		end
		len1 = (len0 != '1) ? len0 + LENGTH_BITS'(1) : len0;
		last = (head.job.flush && at_end) || sc_next ||
			(CMP_W'(len1) > CMP_W'(length_limit));
	end

	// Advance through the job and hold segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_len_q <= '0;
			type_q <= '0;
			type_due_q <= 1'b0;
			at_start_q <= 1'b1;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				seg_len_q <= len1;
				type_q <= ts1;
				type_due_q <= td1;
				at_start_q <= last;
				k_q <= at_end ? 3'd0 : k_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= cur_byte;
			first_q <= first;
			last_q <= last;
			kind_q <= last ? ts1 : 5'd0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.byte_out = byte_q;
	assign out_ch.seg_first = first_q;
	assign out_ch.seg_last = last_q;
	assign out_ch.nal_kind = kind_q;

endmodule
